// File: rtl/awas_pkg.sv
// Package: shared constants, types and CORDIC arctangent table for the wheel angle split.
package awas_pkg;

	localparam int REF_W   = 18;
	localparam int ANG_W   = 19;
	localparam int DLY_W   = 21;
	localparam int WB_W    = 19;
	localparam int HT_W    = 16;
	localparam int SLP_W   = 20;
	localparam int ICP_W   = 16;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 21;

	// Datapath widths: Q4.30 angles, 64-bit vector components.
	localparam int Z_W = 34;
	localparam int V_W = 64;

	localparam logic signed [REF_W-1:0] REF_LIMIT   = 18'sd102944;
	localparam logic signed [ANG_W-1:0] ANGLE_LIMIT = 19'sd205887;
	localparam logic [DLY_W-1:0]        DELAY_MAX   = 21'd2097151;
	localparam logic signed [V_W-1:0]   GAIN_Q30    = 64'sd652032874;
	localparam logic signed [Z_W-1:0]   PI_Q30      = 34'sd3373259426;

	// Register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_WHEELBASE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HALFTRACK = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SLOPE     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_INTERCEPT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FIXED     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ENABLE    = 3'd5;

	// Operation codes for the shared CORDIC unit.
	typedef enum logic {
		OP_ROTATE = 1'b0,
		OP_VECTOR = 1'b1
	} cordic_op_t;

	// Unit control from the sequencer.
	typedef struct packed {
		logic       load;
		logic       step;
		cordic_op_t op;
		logic [4:0] iter;
	} cordic_ctrl_t;

	function automatic logic signed [Z_W-1:0] atan_q30(input logic [4:0] i);
		case (i)
			5'd0:  atan_q30 = 34'sd843314857;
			5'd1:  atan_q30 = 34'sd497837829;
			5'd2:  atan_q30 = 34'sd263043836;
			5'd3:  atan_q30 = 34'sd133525159;
			5'd4:  atan_q30 = 34'sd67021687;
			5'd5:  atan_q30 = 34'sd33543516;
			5'd6:  atan_q30 = 34'sd16775851;
			5'd7:  atan_q30 = 34'sd8388437;
			5'd8:  atan_q30 = 34'sd4194283;
			5'd9:  atan_q30 = 34'sd2097149;
			5'd31: atan_q30 = 34'sd0;
			default: atan_q30 = $signed({{(Z_W-1){1'b0}}, 1'b1}) <<< (30 - i);
		endcase
	endfunction

endpackage

// File: rtl/awas_cordic.sv
// Shared CORDIC iteration unit: one micro-rotation per step, rotation or vectoring.
module awas_cordic
	import awas_pkg::*;
(
	input  logic                  clk,
	input  cordic_ctrl_t          ctrl,
	input  logic signed [V_W-1:0] x_in,
	input  logic signed [V_W-1:0] y_in,
	input  logic signed [Z_W-1:0] z_in,
	output logic signed [V_W-1:0] x,
	output logic signed [V_W-1:0] y,
	output logic signed [Z_W-1:0] z
);

	logic signed [V_W-1:0] x_q, y_q, dx, dy;
	logic signed [Z_W-1:0] z_q, at;
	logic                  dir;

	assign dx = y_q >>> ctrl.iter;
	assign dy = x_q >>> ctrl.iter;
	assign at = atan_q30(ctrl.iter);
	// Rotation follows the sign of z, vectoring drives y to zero.
	// A high dir turns the vector counterclockwise and lowers z.
	assign dir = (ctrl.op == OP_ROTATE) ? (z_q >= 0) : (y_q < 0);

	// Load operands or advance one micro-rotation.
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			x_q <= x_in;
			y_q <= y_in;
			z_q <= z_in;
		end else if (ctrl.step) begin
			if (dir) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + at;
			end
		end
	end

	assign x = x_q;
	assign y = y_q;
	assign z = z_q;

endmodule

// File: rtl/ackermann_wheel_angle_split.sv
// Top level: Ackermann wheel angle split with actuation delay estimate.
//
// Input channel s_axis carries one steering reference (Q2.16) per item. Output
// channel m_axis carries right angle, left angle and delay for each item.
// Configuration channel cfg writes the six geometry and delay registers; write
// only while the block is idle. Indexes beyond the list are ignored.
//
// One shared CORDIC unit first runs the sine/cosine rotation (a load plus
// CORDIC_STEPS iterations), then the product step, then two vectoring passes
// for the right and left atan2 (load, CORDIC_STEPS iterations, capture). A zero
// reference skips the CORDIC passes and goes straight to the result.
// s_axis_tready is high only when no item is in work and the output register
// is free, so a stalled receiver holds the result and blocks new items.
// Reset (arst_n low) restores register defaults and clears the previous reference prev_q.
module ackermann_wheel_angle_split
	import awas_pkg::*;
#(
	parameter int CORDIC_STEPS = 18
)(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [23:0]          s_axis_tdata,  // [17:0] steer_ref
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [63:0]          m_axis_tdata,  // [18:0] right, [37:19] left, [58:38] delay
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data
);

	localparam int NSTEP = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
	localparam logic [4:0] LAST = 5'(NSTEP - 1);

	typedef enum logic [2:0] {
		S_IDLE, S_ROT, S_PROD, S_VLOAD, S_VEC, S_VEND, S_DONE
	} state_t;

	state_t state_q;
	logic [4:0] iter_q;
	logic       side_q;   // 0 right pass, 1 left pass
	logic       busy_q;
	logic       rot_load_q;

	logic [WB_W-1:0]  wb_q;
	logic [HT_W-1:0]  ht_q;
	logic [SLP_W-1:0] slp_q;
	logic [ICP_W-1:0] icp_q;
	logic [DLY_W-1:0] fix_q;
	logic             en_q;
	logic signed [REF_W-1:0] prev_q, ref_q;

	logic signed [V_W-1:0] ls_q, lc_q, hs_q;
	logic signed [ANG_W-1:0] right_q, left_q;
	logic [DLY_W-1:0] dly_q;
	logic out_valid_q;

	cordic_ctrl_t          ctrl;
	logic signed [V_W-1:0] cx, cy, xin, yin;
	logic signed [Z_W-1:0] cz, zin;

	logic signed [REF_W-1:0] ref_in, ref_c;
	logic signed [REF_W:0]   dif;
	logic [REF_W-1:0]        adif;
	logic [SLP_W+REF_W-1:0]  prod;
	logic [SLP_W+REF_W-16:0] dsum;
	logic signed [V_W-1:0]   vx, vy;
	logic signed [Z_W-1:0]   zr;
	logic signed [ANG_W-1:0] ang;
	logic signed [WB_W+32:0] ls_p, lc_p;
	logic signed [HT_W+32:0] hs_p;

	assign ref_in = $signed(s_axis_tdata[REF_W-1:0]);
	assign s_axis_tready = !busy_q && !out_valid_q;
	assign cfg_ready = 1'b1;

	// Clamp the reference for the angle path.
	always_comb begin
		ref_c = ref_q;
		if (ref_q > REF_LIMIT) ref_c = REF_LIMIT;
		if (ref_q < -REF_LIMIT) ref_c = -REF_LIMIT;
	end

	// Delay estimate from the change of reference.
	always_comb begin
		dif  = $signed({prev_q[REF_W-1], prev_q}) - $signed({ref_in[REF_W-1], ref_in});
		adif = dif[REF_W] ? REF_W'(-dif) : dif[REF_W-1:0];
		prod = slp_q * adif;
		dsum = (SLP_W+REF_W-15)'((prod + (SLP_W+REF_W)'(32768)) >> 16) +
			(SLP_W+REF_W-15)'(icp_q);
	end

	// Rotation start from the clamped angle, else vectoring input for the
	// current side, turned by pi when x is negative.
	always_comb begin
		vx = side_q ? (lc_q - hs_q) : (lc_q + hs_q);
		vy = ls_q;
		zin = '0;
		xin = vx;
		yin = vy;
		if (state_q == S_ROT) begin
			xin = GAIN_Q30;
			yin = '0;
			zin = Z_W'(ref_c) <<< 14;
		end else if (vx < 0) begin
			xin = -vx;
			yin = -vy;
			zin = (vy >= 0) ? PI_Q30 : -PI_Q30;
		end
	end

	// Round the final angle and saturate; a zero vector gives a zero angle.
	always_comb begin
		zr = (cz + Z_W'(8192)) >>> 14;
		if (zr > Z_W'(ANGLE_LIMIT)) ang = ANGLE_LIMIT;
		else if (zr < -Z_W'(ANGLE_LIMIT)) ang = -ANGLE_LIMIT;
		else ang = zr[ANG_W-1:0];
		if (vx == 0 && vy == 0) ang = '0;
	end

	// Sine and cosine fit in 32 bits after the gain-compensated rotation.
	assign ls_p = $signed({1'b0, wb_q}) * $signed(cy[31:0]);
	assign lc_p = $signed({1'b0, wb_q}) * $signed(cx[31:0]);
	assign hs_p = $signed({1'b0, ht_q}) * $signed(cy[31:0]);

	always_comb begin
		ctrl.op   = (state_q == S_ROT) ? OP_ROTATE : OP_VECTOR;
		ctrl.iter = iter_q;
		ctrl.load = (state_q == S_VLOAD) || (state_q == S_ROT && rot_load_q);
		ctrl.step = (state_q == S_ROT && !rot_load_q) || (state_q == S_VEC);
	end

	awas_cordic u_cordic (
		.clk  (clk),
		.ctrl (ctrl),
		.x_in (xin),
		.y_in (yin),
		.z_in (zin),
		.x    (cx),
		.y    (cy),
		.z    (cz)
	);

	// Sequencer, registers and output holding.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			iter_q <= '0;
			side_q <= 1'b0;
			busy_q <= 1'b0;
			out_valid_q <= 1'b0;
			rot_load_q <= 1'b0;
			prev_q <= '0;
			ref_q <= '0;
			ls_q <= '0;
			lc_q <= '0;
			hs_q <= '0;
			right_q <= '0;
			left_q <= '0;
			dly_q <= '0;
			wb_q <= 19'd162529;
			ht_q <= 16'd6881;
			slp_q <= 20'd453271;
			icp_q <= 16'd146;
			fix_q <= '0;
			en_q <= 1'b1;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					REG_WHEELBASE: wb_q <= cfg_data[WB_W-1:0];
					REG_HALFTRACK: ht_q <= cfg_data[HT_W-1:0];
					REG_SLOPE:     slp_q <= cfg_data[SLP_W-1:0];
					REG_INTERCEPT: icp_q <= cfg_data[ICP_W-1:0];
					REG_FIXED:     fix_q <= cfg_data;
					REG_ENABLE:    en_q <= cfg_data[0];
					default: ;
				endcase
			end
			if (m_axis_tvalid && m_axis_tready) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid && s_axis_tready) begin
						ref_q <= ref_in;
						prev_q <= ref_in;
						busy_q <= 1'b1;
						if (en_q) dly_q <= (dsum > (SLP_W+REF_W-15)'(DELAY_MAX)) ?
							DELAY_MAX : dsum[DLY_W-1:0];
						else dly_q <= fix_q;
						iter_q <= '0;
						side_q <= 1'b0;
						rot_load_q <= 1'b1;
						if (ref_in == 0) begin
							right_q <= '0;
							left_q <= '0;
							state_q <= S_DONE;
						end else state_q <= S_ROT;
					end
				end
				S_ROT: begin
					if (rot_load_q) rot_load_q <= 1'b0;
					else if (iter_q == LAST) state_q <= S_PROD;
					else iter_q <= iter_q + 5'd1;
				end
				S_PROD: begin
					ls_q <= V_W'(ls_p);
					lc_q <= V_W'(lc_p);
					hs_q <= V_W'(hs_p);
					state_q <= S_VLOAD;
				end
				S_VLOAD: begin
					iter_q <= '0;
					state_q <= S_VEC;
				end
				S_VEC: begin
					if (iter_q == LAST) state_q <= S_VEND;
					else iter_q <= iter_q + 5'd1;
				end
				// Capture the angle after the last iteration.
				S_VEND: begin
					if (side_q) begin
						left_q <= ang;
						state_q <= S_DONE;
					end else begin
						right_q <= ang;
						side_q <= 1'b1;
						state_q <= S_VLOAD;
					end
				end
				S_DONE: begin
					out_valid_q <= 1'b1;
					busy_q <= 1'b0;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = {5'd0, dly_q, left_q, right_q};

	a_busy_ready: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !s_axis_tready) else $error("ready while busy");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid) else $error("result lost");
	a_iter_rng: assert property (@(posedge clk) disable iff (!arst_n)
		iter_q <= LAST) else $error("iteration out of range");

endmodule

// File: dv/testbench.sv
// Testbench for the Ackermann wheel angle split: directed and random steering items checked against a local predictor.
`timescale 1ns / 100ps

module testbench;
	import awas_pkg::*;

	localparam int STEPS = 18;
	localparam int LIMIT_CYCLES = 400000;
	localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [23:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [63:0] m_axis_tdata;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DAT_W-1:0] cfg_data = '0;

	typedef struct packed {
		logic signed [ANG_W-1:0] right_angle;
		logic signed [ANG_W-1:0] left_angle;
		logic [DLY_W-1:0] delay_out;
	} wheel_result_t;

	// Geometry and delay settings mirrored from the register writes
	logic [WB_W-1:0] wheelbase;
	logic [HT_W-1:0] halftrack;
	logic [SLP_W-1:0] slope;
	logic [ICP_W-1:0] intercept;
	logic [DLY_W-1:0] fixed_dly;
	logic estimate_on;
	logic signed [REF_W-1:0] last_ref;

	logic [REF_W-1:0] pending_refs[$];
	wheel_result_t expected_angles[$];
	int errors = 0;
	int cycle_count = 0;
	bit feed_en = 1'b0;
	bit idle_free = 1'b0;
	bit hold_on = 1'b0;

	ackermann_wheel_angle_split #(.CORDIC_STEPS(STEPS)) uut (.*);

	always #10 clk = ~clk;

	function automatic longint atan_entry(int i);
		if (i < 10) begin
			case (i)
				0: return 843314857;
				1: return 497837829;
				2: return 263043836;
				3: return 133525159;
				4: return 67021687;
				5: return 33543516;
				6: return 16775851;
				7: return 8388437;
				8: return 4194283;
				default: return 2097149;
			endcase
		end
		if (i >= 31) return 0;
		return longint'(1) <<< (30 - i);
	endfunction

	function automatic longint vector_angle(longint yy, longint xx);
		longint z, x, y, dx, dy, r;
		z = 0;
		x = xx;
		y = yy;
		if (x == 0 && y == 0) return 0;
		if (x < 0) begin
			z = (y >= 0) ? 64'sd3373259426 : -64'sd3373259426;
			x = -x;
			y = -y;
		end
		for (int i = 0; i < STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y >= 0) begin
				x += dx; y -= dy; z += atan_entry(i);
			end else begin
				x -= dx; y += dy; z -= atan_entry(i);
			end
		end
		r = (z + 8192) >>> 14;
		if (r > 205887) r = 205887;
		if (r < -205887) r = -205887;
		return r;
	endfunction

	// Compute expected wheel angles and delay, advance the previous reference
	function automatic wheel_result_t split_angles(logic [REF_W-1:0] raw);
		wheel_result_t res;
		longint a, x, y, z, dx, dy, ls, lc, hs, d, dly;
		a = longint'($signed(raw));
		res = '0;
		if (a != 0) begin
			z = (a > 102944) ? 102944 : ((a < -102944) ? -102944 : a);
			z = z * 16384;
			x = 652032874;
			y = 0;
			for (int i = 0; i < STEPS; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (z >= 0) begin
					x -= dx; y += dy; z -= atan_entry(i);
				end else begin
					x += dx; y -= dy; z += atan_entry(i);
				end
			end
			ls = longint'(wheelbase) * y;
			lc = longint'(wheelbase) * x;
			hs = longint'(halftrack) * y;
			res.right_angle = ANG_W'(vector_angle(ls, lc + hs));
			res.left_angle = ANG_W'(vector_angle(ls, lc - hs));
		end
		if (estimate_on) begin
			d = longint'(last_ref) - a;
			if (d < 0) d = -d;
			dly = ((longint'(slope) * d + 32768) >>> 16) + longint'(intercept);
			res.delay_out = (dly > 2097151) ? DELAY_MAX : dly[DLY_W-1:0];
		end else begin
			res.delay_out = fixed_dly;
		end
		last_ref = $signed(raw);
		return res;
	endfunction

	// Drive steering items from the pending queue, hold an item until accepted
	always @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			expected_angles.push_back(split_angles(s_axis_tdata[REF_W-1:0]));
			void'(pending_refs.pop_front());
		end
		if (s_axis_tvalid && !s_axis_tready) begin
			s_axis_tvalid <= 1'b1;
		end else if (feed_en && (pending_refs.size() > 0)
				&& (idle_free || $urandom_range(99) >= 20)) begin
			s_axis_tvalid <= 1'b1;
			s_axis_tdata <= {6'd0, pending_refs[0]};
		end else begin
			s_axis_tvalid <= 1'b0;
		end
	end

	// Check results and stall the receiver at random
	always @(posedge clk) begin
		wheel_result_t got, want;
		cycle_count <= cycle_count + 1;
		if (m_axis_tvalid && m_axis_tready) begin
			got.right_angle = m_axis_tdata[18:0];
			got.left_angle = m_axis_tdata[37:19];
			got.delay_out = m_axis_tdata[58:38];
			if (expected_angles.size() == 0) begin
				$display("%0t: unexpected item %h", $time, got);
				errors++;
			end else begin
				want = expected_angles.pop_front();
				if (got.right_angle !== want.right_angle)
					$display("%0t: right exp %0d got %0d", $time,
						want.right_angle, got.right_angle);
				if (got.left_angle !== want.left_angle)
					$display("%0t: left exp %0d got %0d", $time,
						want.left_angle, got.left_angle);
				if (got.delay_out !== want.delay_out)
					$display("%0t: delay exp %0d got %0d", $time,
						want.delay_out, got.delay_out);
				if (got !== want) errors++;
			end
		end
		if (hold_on) begin
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= arst_n && (idle_free || $urandom_range(99) >= 20);
		end
		if (cycle_count > LIMIT_CYCLES) begin
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		cfg_valid <= 1'b0;
		case (idx)
			REG_WHEELBASE: wheelbase = val[WB_W-1:0];
			REG_HALFTRACK: halftrack = val[HT_W-1:0];
			REG_SLOPE: slope = val[SLP_W-1:0];
			REG_INTERCEPT: intercept = val[ICP_W-1:0];
			REG_FIXED: fixed_dly = val;
			REG_ENABLE: estimate_on = val[0];
			default: ;
		endcase
	endtask

	// Let every queued item through and all results drain
	task automatic drain();
		wait (pending_refs.size() == 0 && expected_angles.size() == 0);
		repeat (80) @(posedge clk);
	endtask

	task automatic queue_random(int n, bit wide);
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(5))
				0: pending_refs.push_back(REF_W'($urandom));
				1: pending_refs.push_back($urandom_range(2) == 0 ? 18'h1_9220 :
					($urandom_range(1) ? 18'h2_6DE0 : 18'h0));
				default: pending_refs.push_back(wide ? REF_W'($urandom) :
					18'($signed($urandom_range(205888)) - 102944));
			endcase
		end
	endtask

	initial begin
		logic [REF_W-1:0] directed[] = '{18'h0, 18'h1_9220, 18'h2_6DE0, 18'h1_FFFF,
			18'h2_0000, 18'h0_0001, 18'h3_FFFF, 18'h0, 18'h0_C910, 18'h3_36F0,
			18'h1_A000, 18'h2_5000, 18'h2_AAAA, 18'h1_5555};
		wheelbase = 19'd162529;
		halftrack = 16'd6881;
		slope = 20'd453271;
		intercept = 16'd146;
		fixed_dly = '0;
		estimate_on = 1'b1;
		last_ref = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		// Default settings, directed extremes
		foreach (directed[i]) pending_refs.push_back(directed[i]);
		feed_en = 1'b1;
		drain();

		// Extreme geometry, maximum slope and intercept, a write to an unused index
		write_reg(REG_WHEELBASE, 21'h7FFFF);
		write_reg(REG_HALFTRACK, 21'hFFFF);
		write_reg(REG_SLOPE, 21'hFFFFF);
		write_reg(REG_INTERCEPT, 21'hFFFF);
		write_reg(REG_NONE, 21'h1FFFFF);
		foreach (directed[i]) pending_refs.push_back(directed[i]);
		queue_random(150, 1'b1);
		// Hold off the receiver while items pile up
		fork
			begin
				hold_on = 1'b1;
				repeat (600) @(posedge clk);
				hold_on = 1'b0;
			end
		join_none
		drain();

		write_reg(REG_FIXED, 21'h1FFFFF);
		write_reg(REG_ENABLE, 21'd0);
		write_reg(REG_WHEELBASE, 21'd0);
		write_reg(REG_HALFTRACK, 21'd0);
		queue_random(100, 1'b0);
		drain();

		write_reg(REG_WHEELBASE, 21'd1);
		write_reg(REG_HALFTRACK, 21'hFFFF);
		write_reg(REG_FIXED, 21'd0);
		queue_random(100, 1'b0);
		drain();

		write_reg(REG_WHEELBASE, 21'd162529);
		write_reg(REG_HALFTRACK, 21'd6881);
		write_reg(REG_SLOPE, 21'd0);
		write_reg(REG_INTERCEPT, 21'd0);
		write_reg(REG_ENABLE, 21'd1);
		idle_free = 1'b1;
		queue_random(150, 1'b1);
		drain();
		idle_free = 1'b0;

		write_reg(REG_SLOPE, 21'd453271);
		write_reg(REG_INTERCEPT, 21'd146);
		write_reg(REG_WHEELBASE, CFG_DAT_W'($urandom_range(524287)));
		write_reg(REG_HALFTRACK, CFG_DAT_W'($urandom_range(65535)));
		queue_random(300, 1'b0);
		drain();

		if (errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
